// File: sv/bsmt_pkg.sv
`timescale 1ns / 1ps

package bsmt_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  localparam logic [OPCODE_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_HAS    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic out_full;
  } stat_t;

endpackage

// File: sv/bsmt_if.sv
`timescale 1ns / 1ps

interface bsmt_in_if;
  logic                                valid;
  logic                                ready;
  logic [bsmt_pkg::OPCODE_W-1:0]       opcode;
  logic signed [bsmt_pkg::VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface bsmt_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsmt_pkg::STATUS_W-1:0] status;
  logic [bsmt_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output occupancy, input ready);
  modport sink (input valid, input status, input occupancy, output ready);
endinterface

// File: sv/bsmt_ctrl.sv
`timescale 1ns / 1ps

module bsmt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bsmt_pkg::stat_t stat,
  output bsmt_pkg::cmd_t  cmd
);

  bsmt_pkg::state_t state_r;
  bsmt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsmt_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      bsmt_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = bsmt_pkg::S_IDLE;
        end
      end
      bsmt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bsmt_pkg::S_SCAN;
        end
      end
      bsmt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = bsmt_pkg::S_DRAIN;
        end
      end
      bsmt_pkg::S_DRAIN: begin
        state_nxt = bsmt_pkg::S_FINISH;
      end
      bsmt_pkg::S_FINISH: begin
        if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = bsmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bsmt_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// File: sv/bsmt_dp.sv
`timescale 1ns / 1ps

module bsmt_dp #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsmt_pkg::cmd_t                      cmd,
  output bsmt_pkg::stat_t                     stat,
  input  logic [bsmt_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic signed [bsmt_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsmt_pkg::STATUS_W-1:0]       out_status,
  output logic [bsmt_pkg::OCC_W-1:0]          out_occupancy
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

  // word layout: valid bit above the stored value
  logic [DATA_WIDTH:0] mem [CAPACITY];

  logic [AW-1:0]                   clr_addr_r;
  logic [AW-1:0]                   rd_addr_r;
  logic [AW-1:0]                   cmp_addr_r;
  logic                            cmp_vld_r;
  logic [DATA_WIDTH:0]             rd_data_r;
  logic [bsmt_pkg::OPCODE_W-1:0]   op_r;
  logic [DATA_WIDTH-1:0]           key_r;
  logic                            found_r;
  logic                            free_found_r;
  logic [AW-1:0]                   free_addr_r;
  logic [CW-1:0]                   count_r;
  logic [CW-1:0]                   count_nxt;
  logic                            out_valid_r;
  logic [bsmt_pkg::STATUS_W-1:0]   out_status_r;
  logic [bsmt_pkg::OCC_W-1:0]      out_occ_r;

  logic [DATA_WIDTH+bsmt_pkg::VALUE_W-1:0] key_ext;
  logic [CW+bsmt_pkg::OCC_W-1:0]           occ_ext;
  logic                                    hit;
  logic                                    free_slot;
  logic                                    rem_hit;
  logic                                    do_put;
  logic [bsmt_pkg::STATUS_W-1:0]           status_nxt;

  assign key_ext   = {{DATA_WIDTH{1'b0}}, in_value};
  assign hit       = cmp_vld_r && rd_data_r[DATA_WIDTH] && (rd_data_r[DATA_WIDTH-1:0] == key_r);
  assign free_slot = cmp_vld_r && !rd_data_r[DATA_WIDTH];
  assign rem_hit   = hit && (op_r == bsmt_pkg::OP_REMOVE);
  assign do_put    = cmd.finish && (op_r == bsmt_pkg::OP_PUT) && !found_r && free_found_r;

  always_comb begin
    count_nxt = count_r;
    if (rem_hit && (count_r != '0)) begin
      count_nxt = count_r - CW'(1);
    end else if (do_put) begin
      count_nxt = count_r + CW'(1);
    end
  end

  assign occ_ext = {{bsmt_pkg::OCC_W{1'b0}}, count_nxt};

  always_comb begin
    status_nxt = bsmt_pkg::ST_OK;
    if ((op_r == bsmt_pkg::OP_PUT) && !found_r && !free_found_r) begin
      status_nxt = bsmt_pkg::ST_FULL;
    end else if ((op_r == bsmt_pkg::OP_HAS) && !found_r) begin
      status_nxt = bsmt_pkg::ST_ABSENT;
    end
  end

  // single write port: clearing pass, put, remove
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr_r] <= '0;
    end else if (do_put) begin
      mem[free_addr_r] <= {1'b1, key_r};
    end else if (rem_hit) begin
      mem[cmp_addr_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r  <= mem[rd_addr_r];
    cmp_addr_r <= rd_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      rd_addr_r    <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      cmp_vld_r <= cmd.scan;
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.load) begin
        rd_addr_r    <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (cmd.scan) begin
          rd_addr_r <= rd_addr_r + AW'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
        if (free_slot && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      key_r <= key_ext[DATA_WIDTH-1:0];
    end
    if (free_slot && !free_found_r) begin
      free_addr_r <= cmp_addr_r;
    end
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_occ_r    <= occ_ext[bsmt_pkg::OCC_W-1:0];
    end
  end

  assign stat.clear_last = (clr_addr_r == LAST_ADDR);
  assign stat.scan_last  = (rd_addr_r == LAST_ADDR);
  assign stat.out_full   = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

// File: sv/bounded_set_membership_table_top.sv
`timescale 1ns / 1ps

// channel   direction  fields                          handshake
// in_ch     sink       opcode[1:0], value[31:0] signed valid / ready
// out_ch    source     status[1:0], occupancy[6:0]     valid / ready
//
// one item at a time, in_ch.ready low until it is done: accept, a scan of the
// entry memory through its single read port, a drain state, a result state
// after reset a clearing pass over every entry runs before in_ch.ready rises
// a result waiting on out_ch holds the block in its result state until taken;
// a held result does not block the next accept

module bounded_set_membership_table_top #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  bsmt_in_if.sink    in_ch,
  bsmt_out_if.source out_ch
);

  bsmt_pkg::cmd_t  cmd;
  bsmt_pkg::stat_t stat;

  bsmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsmt_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_ch.opcode),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_occupancy (out_ch.occupancy)
  );

endmodule

// File: sv/bsmt_checker.sv
`timescale 1ns / 1ps

module bsmt_checker #(
  parameter int CAPACITY = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bsmt_pkg::STATUS_W-1:0] out_status,
  input logic [bsmt_pkg::OCC_W-1:0]    out_occupancy
);

  localparam logic [bsmt_pkg::OCC_W-1:0] CAP_OCC = bsmt_pkg::OCC_W'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_occupancy))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted during a scan");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (CAPACITY < 128) |-> out_occupancy <= CAP_OCC)
    else $error("occupancy above capacity");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bsmt_pkg::ST_FULL) |-> out_occupancy == CAP_OCC)
    else $error("full status with free entries");

endmodule

bind bounded_set_membership_table_top bsmt_checker #(
  .CAPACITY (CAPACITY)
) u_bsmt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_occupancy (out_ch.occupancy)
);

// File: tb/sv/tb_bounded_set_membership_table_top.sv
`timescale 1ns / 1ps

module tb_bounded_set_membership_table_top;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int POOL_N     = 96;
  localparam int N_RANDOM   = 1025;

  // opcode three is unused by the block
  localparam logic [bsmt_pkg::OPCODE_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [bsmt_pkg::OPCODE_W-1:0]       opcode;
    logic signed [bsmt_pkg::VALUE_W-1:0] value;
  } table_op_t;

  typedef struct packed {
    logic [bsmt_pkg::STATUS_W-1:0] status;
    logic [bsmt_pkg::OCC_W-1:0]    occupancy;
  } table_reply_t;

  logic clk;
  logic rst_n;

  bsmt_in_if  in_ch ();
  bsmt_out_if out_ch ();

  bounded_set_membership_table_top #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];

  logic [DATA_WIDTH-1:0] shadow_value[CAPACITY];
  bit                    shadow_used[CAPACITY];
  int unsigned           shadow_count;

  logic [bsmt_pkg::VALUE_W-1:0] value_pool[POOL_N];

  int error_count    = 0;
  int total_items    = 0;
  int accepted_items = 0;
  int counted_items  = 0;
  int in_gap         = 0;
  int out_stall      = 0;
  int phase_left     = 0;
  bit calm           = 1'b0;
  bit in_fire        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic table_reply_t predict_table_op(input table_op_t item);
    table_reply_t          r;
    logic [DATA_WIDTH-1:0] v;
    bit                    hit;
    int                    slot;
    v        = item.value[DATA_WIDTH-1:0];
    r.status = bsmt_pkg::ST_OK;
    hit      = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_used[i] && shadow_value[i] == v) hit = 1'b1;
    end
    case (item.opcode)
      bsmt_pkg::OP_PUT: begin
        if (!hit) begin
          slot = -1;
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!shadow_used[i]) slot = i;
          end
          if (slot < 0) begin
            r.status = bsmt_pkg::ST_FULL;
          end else begin
            shadow_value[slot] = v;
            shadow_used[slot]  = 1'b1;
            shadow_count++;
          end
        end
      end
      bsmt_pkg::OP_HAS: begin
        if (!hit) r.status = bsmt_pkg::ST_ABSENT;
      end
      bsmt_pkg::OP_REMOVE: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (shadow_used[i] && shadow_value[i] == v) begin
            shadow_used[i] = 1'b0;
            if (shadow_count > 0) shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[bsmt_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic add_op(input logic [bsmt_pkg::OPCODE_W-1:0] op,
                        input logic [bsmt_pkg::VALUE_W-1:0] v);
    pending_ops.push_back('{opcode: op, value: v});
    if (op != OP_NONE) counted_items++;
  endtask

  function automatic logic [bsmt_pkg::VALUE_W-1:0] pick_value();
    logic [bsmt_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 31) - 16;
      3: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h8000_0001;
          default: v = 32'h7FFF_FFFE;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic build_stimulus();
    int sel;
    int len;
    int start;
    int r;
    int put_w;
    int has_w;
    logic [bsmt_pkg::VALUE_W-1:0] v;

    // directed: empty table, extremes, repeats, absent values, unused opcode
    add_op(bsmt_pkg::OP_HAS,    32'h0000_0000);
    add_op(bsmt_pkg::OP_REMOVE, 32'h0000_0005);
    add_op(bsmt_pkg::OP_PUT,    32'h8000_0000);
    add_op(bsmt_pkg::OP_PUT,    32'h7FFF_FFFF);
    add_op(bsmt_pkg::OP_PUT,    32'h0000_0000);
    add_op(bsmt_pkg::OP_PUT,    32'hFFFF_FFFF);
    add_op(bsmt_pkg::OP_PUT,    32'h7FFF_FFFF);
    add_op(bsmt_pkg::OP_HAS,    32'h8000_0000);
    add_op(bsmt_pkg::OP_HAS,    32'h7FFF_FFFF);
    add_op(bsmt_pkg::OP_HAS,    32'hFFFF_FFFF);
    add_op(bsmt_pkg::OP_HAS,    32'h0000_0001);
    add_op(bsmt_pkg::OP_HAS,    32'h8000_0001);
    add_op(bsmt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    add_op(bsmt_pkg::OP_HAS,    32'hFFFF_FFFF);
    add_op(bsmt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    add_op(OP_NONE,             32'hA5A5_A5A5);
    add_op(OP_NONE,             32'h5A5A_5A5A);
    add_op(bsmt_pkg::OP_PUT,    32'h5555_5555);
    add_op(bsmt_pkg::OP_PUT,    32'hAAAA_AAAA);
    add_op(bsmt_pkg::OP_HAS,    32'hAAAA_AAAA);
    add_op(bsmt_pkg::OP_REMOVE, 32'h0000_0000);
    add_op(bsmt_pkg::OP_PUT,    32'h0000_0000);
    add_op(bsmt_pkg::OP_REMOVE, 32'h8000_0000);
    add_op(bsmt_pkg::OP_REMOVE, 32'h7FFF_FFFF);

    for (int i = 0; i < POOL_N; i++) value_pool[i] = pick_value();
    counted_items = 0;

    while (counted_items < N_RANDOM) begin
      sel = $urandom_range(0, 9);
      if (sel <= 1) begin
        // clear the old pool, then fill past capacity with a fresh one
        for (int i = 0; i < POOL_N; i++) add_op(bsmt_pkg::OP_REMOVE, value_pool[i]);
        for (int i = 0; i < POOL_N; i++) value_pool[i] = pick_value();
        start = $urandom_range(0, POOL_N - 1);
        len   = CAPACITY + 8 + $urandom_range(0, 24);
        for (int k = 0; k < len; k++) begin
          add_op(bsmt_pkg::OP_PUT, value_pool[(start + k) % POOL_N]);
        end
        for (int k = 0; k < 6; k++) begin
          add_op(bsmt_pkg::OP_HAS, value_pool[$urandom_range(0, POOL_N - 1)]);
        end
      end else if (sel == 2) begin
        for (int i = 0; i < POOL_N; i++) begin
          if ($urandom_range(0, 9) == 0) add_op(bsmt_pkg::OP_HAS, value_pool[i]);
          else add_op(bsmt_pkg::OP_REMOVE, value_pool[i]);
        end
      end else begin
        if (sel <= 5) begin
          put_w = 60;
          has_w = 25;
        end else if (sel <= 7) begin
          put_w = 35;
          has_w = 35;
        end else begin
          put_w = 20;
          has_w = 30;
        end
        len = $urandom_range(20, 80);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 2) begin
            add_op(OP_NONE, $urandom);
          end else if (r < 8) begin
            // stray value, cleaned up so it does not eat capacity
            v = $urandom;
            if ($urandom_range(0, 1) == 0) begin
              add_op(bsmt_pkg::OP_HAS, v);
            end else begin
              add_op(bsmt_pkg::OP_PUT, v);
              add_op(bsmt_pkg::OP_HAS, v);
              add_op(bsmt_pkg::OP_REMOVE, v);
            end
          end else begin
            v = value_pool[$urandom_range(0, POOL_N - 1)];
            r = $urandom_range(0, 99);
            if (r < put_w) add_op(bsmt_pkg::OP_PUT, v);
            else if (r < put_w + has_w) add_op(bsmt_pkg::OP_HAS, v);
            else add_op(bsmt_pkg::OP_REMOVE, v);
          end
        end
      end
    end
    total_items = pending_ops.size();
  endtask

  // driver and idling, inputs change on the falling edge
  always @(negedge clk) begin : drive
    table_op_t nxt;
    bit        quiet;
    quiet = (accepted_items + 100 >= total_items);
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(50, 400);
        calm       <= ($urandom_range(0, 3) == 0);
      end else begin
        phase_left <= phase_left - 1;
      end

      if (in_ch.valid && !in_fire) begin
        // hold the item until taken
      end else if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (pending_ops.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= $urandom_range(0, 16);
      end else begin
        nxt = pending_ops.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= nxt.opcode;
        in_ch.value  <= nxt.value;
      end

      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= $urandom_range(0, 16);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // prediction on accept, comparison on every result
  always @(posedge clk) begin : monitor
    table_reply_t want;
    in_fire <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_replies.push_back(predict_table_op('{opcode: in_ch.opcode, value: in_ch.value}));
      accepted_items <= accepted_items + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result: status %0d occupancy %0d", out_ch.status, out_ch.occupancy);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.occupancy !== want.occupancy) begin
          $error("occupancy mismatch: expected %0d actual %0d", want.occupancy,
                 out_ch.occupancy);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = bsmt_pkg::OP_PUT;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    shadow_count = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_used[i]  = 1'b0;
      shadow_value[i] = '0;
    end
    build_stimulus();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/bsmt_pkg.sv
sv/bsmt_if.sv
sv/bsmt_ctrl.sv
sv/bsmt_dp.sv
sv/bounded_set_membership_table_top.sv
sv/bsmt_checker.sv
tb/sv/tb_bounded_set_membership_table_top.sv
